>>> sv/rfa_pkg.sv
// ----------------------------------------------------------------------------
// Rastrigin fitness package
// Shared widths, constants and the elaborated cosine term tables.
// ----------------------------------------------------------------------------
package rfa_pkg;

   localparam int COORD_W     = 24;
   localparam int FRAC_W      = 16;
   localparam int PHASE_BITS  = 10;
   localparam int PHASE_N     = 1 << PHASE_BITS;
   localparam int PHASE_HALF  = PHASE_N / 2;
   localparam int QUARTER     = PHASE_N / 4;
   localparam int ROM_AW      = PHASE_BITS - 1;
   localparam int ENTRY_W     = 21;
   localparam int SQ_W        = 2 * COORD_W - FRAC_W - 1;
   localparam int TERM_W      = SQ_W + 1;
   localparam int SUM_W       = 48;
   localparam int IDX_W       = 10;
   localparam int MAX_VECTORS = 1024;
   localparam int COUNT_W     = $clog2(MAX_VECTORS);

   localparam longint unsigned ONE_Q30    = 64'd1073741824;
   localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
   localparam longint unsigned TAYLOR_DIV [0:6] = '{240, 182, 132, 90, 56, 30, 12};

   typedef logic [ENTRY_W-1:0] rom_type [0:QUARTER];

   // One table entry: 10 - 10*cos of a folded phase, Q.16, rounded half up.
   function automatic logic [ENTRY_W-1:0] cos_entry(int unsigned u, bit neg);
      longint unsigned a;
      longint unsigned a2;
      longint unsigned h;
      longint unsigned p;
      longint unsigned c;
      longint unsigned v;
      a  = (64'(u) * TWO_PI_Q30) >> PHASE_BITS;
      a2 = (a * a) >> 30;
      h  = ONE_Q30;
      for (int i = 0; i < 7; i++) begin
         h = ONE_Q30 - ((a2 * h) >> 30) / TAYLOR_DIV[i];
      end
      p = (a2 * h) >> 31;
      c = (p >= ONE_Q30) ? 64'd0 : ONE_Q30 - p;
      v = neg ? ONE_Q30 + c : ONE_Q30 - c;
      return ENTRY_W'((64'd10 * v + 64'd8192) >> 14);
   endfunction

   function automatic rom_type build_rom(bit neg);
      rom_type r;
      for (int j = 0; j <= QUARTER; j++) begin
         r[j] = cos_entry(j, neg);
      end
      return r;
   endfunction

   localparam rom_type COS_ROM_POS = build_rom(1'b0);
   localparam rom_type COS_ROM_NEG = build_rom(1'b1);

endpackage

>>> sv/rfa_if.sv
// ----------------------------------------------------------------------------
// Rastrigin fitness channels
// Valid/ready channels for coordinate words and result words.
// ----------------------------------------------------------------------------
interface rfa_req_if;
   logic                          valid;
   logic                          ready;
   logic [rfa_pkg::COORD_W-1:0]   coord;
   logic                          last_coord;
   logic                          population_start;

   modport source (output valid, coord, last_coord, population_start, input ready);
   modport sink   (input valid, coord, last_coord, population_start, output ready);
endinterface

interface rfa_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rfa_pkg::IDX_W-1:0]     vector_index;
   logic [rfa_pkg::SUM_W-1:0]     fitness_value;
   logic [rfa_pkg::IDX_W-1:0]     best_index;
   logic [rfa_pkg::SUM_W-1:0]     best_value;
   logic                          improved;

   modport source (output valid, vector_index, fitness_value, best_index, best_value,
                   improved, input ready);
   modport sink   (input valid, vector_index, fitness_value, best_index, best_value,
                   improved, output ready);
endinterface

>>> sv/rastrigin_fitness_argmin_top.sv
// ----------------------------------------------------------------------------
// Rastrigin fitness with running minimum
// Accumulates per-coordinate Rastrigin terms and tracks the best vector.
//
//   channel   | dir | word
//   req_chan  | in  | coord, last_coord, population_start
//   rsp_chan  | out | vector_index, fitness_value, best_index, best_value, improved
//
// A coordinate word is accepted every cycle while no result word is held; the last
// coordinate of a vector reaches the result word through the input register, the
// term register with the square and table read, and the accumulator feeding the
// result register.
// Reset is synchronous and clears the pipeline valids and the running state.
// A held result word stalls the whole pipeline, and req_chan.ready drops.
// ----------------------------------------------------------------------------
module rastrigin_fitness_argmin_top (
   input logic      clock,
   input logic      reset,
   rfa_req_if.sink  req_chan,
   rfa_rsp_if.source rsp_chan
);

   logic                              advance;

   logic                              a_valid_ff;
   logic [rfa_pkg::COORD_W-1:0]       a_coord_ff;
   logic                              a_last_ff;
   logic                              a_start_ff;

   logic                              b_valid_ff;
   logic [rfa_pkg::TERM_W-1:0]        b_term_ff;
   logic [rfa_pkg::TERM_W-1:0]        b_term_in;
   logic                              b_last_ff;
   logic                              b_start_ff;

   logic [rfa_pkg::SUM_W-1:0]         sum_ff;
   logic [rfa_pkg::SUM_W-1:0]         sum_in;
   logic [rfa_pkg::COUNT_W-1:0]       count_ff;
   logic [rfa_pkg::COUNT_W-1:0]       count_in;
   logic [rfa_pkg::SUM_W-1:0]         low_value_ff;
   logic [rfa_pkg::SUM_W-1:0]         low_value_in;
   logic [rfa_pkg::COUNT_W-1:0]       low_index_ff;
   logic [rfa_pkg::COUNT_W-1:0]       low_index_in;
   logic                              have_low_ff;
   logic                              have_low_in;

   logic                              out_valid_ff;
   logic [rfa_pkg::IDX_W-1:0]         out_index_ff;
   logic [rfa_pkg::SUM_W-1:0]         out_fit_ff;
   logic [rfa_pkg::IDX_W-1:0]         out_best_index_ff;
   logic [rfa_pkg::SUM_W-1:0]         out_best_value_ff;
   logic                              out_improved_ff;

   logic [rfa_pkg::COORD_W-1:0]       mag;
   logic [2*rfa_pkg::COORD_W-1:0]     sq_full;
   logic [rfa_pkg::PHASE_BITS-1:0]    phase;
   logic [rfa_pkg::PHASE_BITS:0]      mirror;
   logic [rfa_pkg::PHASE_BITS-1:0]    fold;
   logic [rfa_pkg::PHASE_BITS-1:0]    fold_back;
   logic                              neg;
   logic [rfa_pkg::ROM_AW-1:0]        rom_addr;
   logic [rfa_pkg::ENTRY_W-1:0]       entry;

   logic [rfa_pkg::SUM_W-1:0]         base_sum;
   logic [rfa_pkg::COUNT_W-1:0]       base_count;
   logic [rfa_pkg::SUM_W-1:0]         base_low_value;
   logic [rfa_pkg::COUNT_W-1:0]       base_low_index;
   logic                              base_have_low;
   logic [rfa_pkg::SUM_W:0]           fit_wide;
   logic [rfa_pkg::SUM_W-1:0]         fit;
   logic                              improve;

   assign advance        = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_chan.valid;
      end
      if (advance) begin
         a_coord_ff <= req_chan.coord;
         a_last_ff  <= req_chan.last_coord;
         a_start_ff <= req_chan.population_start;
      end
   end

   // Square of the magnitude and the folded cosine table lookup.
   always_comb begin
      mag     = a_coord_ff[rfa_pkg::COORD_W-1] ? (~a_coord_ff + 1'b1) : a_coord_ff;
      sq_full = mag * mag;
      phase   = a_coord_ff[rfa_pkg::FRAC_W-1 -: rfa_pkg::PHASE_BITS];
      mirror  = (rfa_pkg::PHASE_BITS+1)'(rfa_pkg::PHASE_N) - {1'b0, phase};
      fold    = (phase > rfa_pkg::PHASE_BITS'(rfa_pkg::PHASE_HALF))
                ? mirror[rfa_pkg::PHASE_BITS-1:0] : phase;
      fold_back = rfa_pkg::PHASE_BITS'(rfa_pkg::PHASE_HALF) - fold;
      neg     = fold > rfa_pkg::PHASE_BITS'(rfa_pkg::QUARTER);
      rom_addr = neg ? fold_back[rfa_pkg::ROM_AW-1:0] : fold[rfa_pkg::ROM_AW-1:0];
      entry   = neg ? rfa_pkg::COS_ROM_NEG[rom_addr] : rfa_pkg::COS_ROM_POS[rom_addr];
      b_term_in = rfa_pkg::TERM_W'(sq_full[rfa_pkg::FRAC_W +: rfa_pkg::SQ_W])
                  + rfa_pkg::TERM_W'(entry);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid_ff;
      end
      if (advance) begin
         b_term_ff  <= b_term_in;
         b_last_ff  <= a_last_ff;
         b_start_ff <= a_start_ff;
      end
   end

   // Accumulate with saturation and update the running minimum.
   always_comb begin
      base_sum       = b_start_ff ? '0 : sum_ff;
      base_count     = b_start_ff ? '0 : count_ff;
      base_low_value = b_start_ff ? '1 : low_value_ff;
      base_low_index = b_start_ff ? '0 : low_index_ff;
      base_have_low  = b_start_ff ? 1'b0 : have_low_ff;

      fit_wide = {1'b0, base_sum} + (rfa_pkg::SUM_W+1)'(b_term_ff);
      fit      = fit_wide[rfa_pkg::SUM_W] ? '1 : fit_wide[rfa_pkg::SUM_W-1:0];
      improve  = b_last_ff && (!base_have_low || fit < base_low_value);

      sum_in       = b_last_ff ? '0 : fit;
      count_in     = base_count;
      if (b_last_ff) begin
         count_in = ((rfa_pkg::COUNT_W+1)'(base_count) + 1'b1
                     >= (rfa_pkg::COUNT_W+1)'(rfa_pkg::MAX_VECTORS))
                    ? '0 : base_count + 1'b1;
      end
      low_value_in = improve ? fit : base_low_value;
      low_index_in = improve ? base_count : base_low_index;
      have_low_in  = base_have_low || improve;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         count_ff     <= '0;
         low_value_ff <= '1;
         low_index_ff <= '0;
         have_low_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= b_valid_ff && b_last_ff;
         if (b_valid_ff) begin
            sum_ff       <= sum_in;
            count_ff     <= count_in;
            low_value_ff <= low_value_in;
            low_index_ff <= low_index_in;
            have_low_ff  <= have_low_in;
         end
      end
      if (advance) begin
         out_index_ff      <= rfa_pkg::IDX_W'(base_count);
         out_fit_ff        <= fit;
         out_best_index_ff <= rfa_pkg::IDX_W'(low_index_in);
         out_best_value_ff <= low_value_in;
         out_improved_ff   <= improve;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.vector_index  = out_index_ff;
   assign rsp_chan.fitness_value = out_fit_ff;
   assign rsp_chan.best_index    = out_best_index_ff;
   assign rsp_chan.best_value    = out_best_value_ff;
   assign rsp_chan.improved      = out_improved_ff;

endmodule
